// File: design/vln_pkg.sv
// shared constants, codes and types of the vector l2 normaliser
package vln_pkg;

   // fixed field widths, division steps and queue depth
   localparam int VALUE_W = 16;
   localparam int TINY_W = 20;
   localparam int SUM_W = 40;
   localparam int ROOT_W = 20;
   localparam int FRAC_BITS = 12;
   localparam int QUOT_W = 16;
   localparam int DIV_STEPS = 4;
   localparam int QUEUE_DEPTH = 4;

   // parameter defaults
   localparam int VECTOR_LEN_DEF = 512;
   localparam int ELEMENT_BITS_DEF = 16;

   typedef enum logic [1:0] {
      OP_LOAD      = 2'd0,
      OP_LOAD_LAST = 2'd1,
      OP_READ      = 2'd2
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  element;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_ROOT,
      ST_FETCH,
      ST_DIVIDE,
      ST_EMIT
   } back_state_type;

endpackage

// File: design/vln_if.sv
// channel interfaces: request, response and register write
interface vln_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic signed [vln_pkg::VALUE_W-1:0]   element_value;
   logic                                 last_element;

   modport source (output valid, kind, element_value, last_element, input ready);
   modport sink (input valid, kind, element_value, last_element, output ready);
endinterface

interface vln_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [vln_pkg::VALUE_W-1:0]   normalized_value;
   logic                                 last_result;
   logic                                 error_flag;

   modport source (output valid, normalized_value, last_result, error_flag, input ready);
   modport sink (input valid, normalized_value, last_result, error_flag, output ready);
endinterface

interface vln_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [vln_pkg::TINY_W-1:0]           tiny_sum_squares;

   modport source (output valid, tiny_sum_squares, input ready);
   modport sink (input valid, tiny_sum_squares, output ready);
endinterface

// File: design/vln_front.sv
// front end: takes request transfers, decodes the operation, clamps the element
module vln_front #(
   parameter int ELEMENT_BITS = vln_pkg::ELEMENT_BITS_DEF
) (
   vln_req_if.sink                    req,
   input  vln_pkg::queue_status_type  status,
   output logic                       push_valid,
   output vln_pkg::cmd_type           push_cmd
);

   localparam int VALUE_W = vln_pkg::VALUE_W;
   localparam int STORE_W = (ELEMENT_BITS < VALUE_W) ? ELEMENT_BITS : VALUE_W;
   localparam logic signed [VALUE_W-1:0] ELEM_HI = VALUE_W'((1 << (STORE_W - 1)) - 1);
   localparam logic signed [VALUE_W-1:0] ELEM_LO = ~ELEM_HI;

   logic signed [VALUE_W-1:0] clamped;

   assign req.ready  = !status.full;
   assign push_valid = req.valid && !status.full;

   // saturate to the element range
   always_comb begin
      if (req.element_value > ELEM_HI) begin
         clamped = ELEM_HI;
      end else if (req.element_value < ELEM_LO) begin
         clamped = ELEM_LO;
      end else begin
         clamped = req.element_value;
      end
   end

   always_comb begin
      push_cmd.element = clamped;
      if (req.kind) begin
         push_cmd.op = vln_pkg::OP_READ;
      end else if (req.last_element) begin
         push_cmd.op = vln_pkg::OP_LOAD_LAST;
      end else begin
         push_cmd.op = vln_pkg::OP_LOAD;
      end
   end

endmodule

// File: design/vln_queue.sv
// short command queue between front and back end
module vln_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  vln_pkg::cmd_type           push_cmd,
   input  logic                       pop,
   output vln_pkg::cmd_type           pop_cmd,
   output vln_pkg::queue_status_type  status
);

   localparam int DEPTH = vln_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   vln_pkg::cmd_type   entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign do_pop       = pop && (count_ff != '0);
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_cmd      = entries_ff[rd_ptr_ff];

   assign wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !status.full)
      else $error("queue written while full");
`endif

endmodule

// File: design/vln_back.sv
// back end: element store, sum of squares, square root, division and result register
module vln_back #(
   parameter int VECTOR_LEN   = vln_pkg::VECTOR_LEN_DEF,
   parameter int ELEMENT_BITS = vln_pkg::ELEMENT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [vln_pkg::TINY_W-1:0]  tiny_sum_squares,
   input  vln_pkg::queue_status_type   status,
   input  vln_pkg::cmd_type            pop_cmd,
   output logic                        pop,
   vln_rsp_if.source                   rsp
);

   localparam int VALUE_W    = vln_pkg::VALUE_W;
   localparam int SUM_W      = vln_pkg::SUM_W;
   localparam int ROOT_W     = vln_pkg::ROOT_W;
   localparam int QUOT_W     = vln_pkg::QUOT_W;
   localparam int FRAC_BITS  = vln_pkg::FRAC_BITS;
   localparam int DIV_STEPS  = vln_pkg::DIV_STEPS;
   localparam int STORE_W    = (ELEMENT_BITS < VALUE_W) ? ELEMENT_BITS : VALUE_W;
   localparam int CNT_W      = $clog2(VECTOR_LEN + 1);
   localparam int ADDR_W     = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
   localparam int SQ_W       = 2 * STORE_W;
   localparam int SAT_SH     = QUOT_W - FRAC_BITS;
   localparam int ROOT_STEPS = SUM_W / 2;
   localparam int STEP_W     = $clog2(ROOT_STEPS);
   localparam int DIV_CYCLES = QUOT_W / DIV_STEPS;
   localparam int DCNT_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam logic [VALUE_W-1:0] SAT_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [VALUE_W-1:0] SAT_POS = ~SAT_NEG;

   vln_pkg::back_state_type state_ff, state_in;

   // vector state
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          pos_ff, pos_in;
   logic                      ready_ff, ready_in;
   logic                      overfill_ff, overfill_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [ROOT_W-1:0]         norm_ff, norm_in;

   // load path
   logic [SQ_W-1:0]           sq_ff, sq_in;
   logic                      close_ff, close_in;

   // square root
   logic [SUM_W-1:0]          root_src_ff, root_src_in;
   logic [ROOT_W+1:0]         root_rem_ff, root_rem_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [STEP_W-1:0]         step_ff, step_in;

   // read path
   logic                      skip_ff, skip_in;
   logic                      last_ff, last_in;
   logic                      err_ff, err_in;
   logic                      neg_ff, neg_in;
   logic                      use_q_ff, use_q_in;
   logic [VALUE_W-1:0]        res_ff, res_in;
   logic [ROOT_W:0]           div_rem_ff, div_rem_in;
   logic [QUOT_W-1:0]         div_bits_ff, div_bits_in;
   logic [QUOT_W-1:0]         quot_ff, quot_in;
   logic [DCNT_W-1:0]         dcnt_ff, dcnt_in;

   // result register
   logic                      out_valid_ff, out_valid_in;
   logic [VALUE_W-1:0]        out_value_ff, out_value_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_err_ff, out_err_in;

   // element store
   logic signed [STORE_W-1:0] mem [VECTOR_LEN];
   logic signed [STORE_W-1:0] rd_ff;
   logic                      mem_we, mem_re;
   logic [ADDR_W-1:0]         mem_waddr, mem_raddr;

   // helpers
   logic [CNT_W-1:0]          count_eff;
   logic signed [STORE_W-1:0] elem_v;
   logic signed [SQ_W-1:0]    sq_prod;
   logic [SUM_W:0]            accum_sum;
   logic [SUM_W-1:0]          accum_sat;
   logic [ROOT_W+3:0]         root_wrk, root_trial, root_diff;
   logic                      root_ge;
   logic                      rd_neg;
   logic [STORE_W-1:0]        rd_mag;
   logic [VALUE_W-1:0]        mag16;
   logic                      div_sat;
   logic [ROOT_W:0]           div_rem_nx;
   logic [QUOT_W-1:0]         div_bits_nx, quot_nx;
   logic [VALUE_W-1:0]        q_final;
   logic                      out_free;

   assign count_eff = ready_ff ? '0 : count_ff;
   assign elem_v    = pop_cmd.element[STORE_W-1:0];
   assign sq_prod   = elem_v * elem_v;

   assign accum_sum = {1'b0, sum_ff} + (SUM_W + 1)'(sq_ff);
   assign accum_sat = accum_sum[SUM_W] ? '1 : accum_sum[SUM_W-1:0];

   assign root_wrk   = {root_rem_ff, root_src_ff[SUM_W-1 -: 2]};
   assign root_trial = (ROOT_W + 4)'({root_ff, 2'b01});
   assign root_diff  = root_wrk - root_trial;
   assign root_ge    = (root_wrk >= root_trial);

   assign rd_neg  = rd_ff[STORE_W-1];
   assign rd_mag  = rd_neg ? STORE_W'(~rd_ff + 1'b1) : STORE_W'(rd_ff);
   assign mag16   = VALUE_W'(rd_mag);
   assign div_sat = ((ROOT_W + SAT_SH)'(mag16) >= {norm_ff, {SAT_SH{1'b0}}});

   assign mem_waddr = count_eff[ADDR_W-1:0];
   assign mem_raddr = pos_ff[ADDR_W-1:0];

   assign out_free = !out_valid_ff || rsp.ready;

   // a few restoring division steps per cycle
   always_comb begin : div_steps
      logic [ROOT_W:0]   r;
      logic [QUOT_W-1:0] b;
      logic [QUOT_W-1:0] q;
      r = div_rem_ff;
      b = div_bits_ff;
      q = quot_ff;
      for (int k = 0; k < DIV_STEPS; k++) begin
         r = {r[ROOT_W-1:0], b[QUOT_W-1]};
         b = b << 1;
         if (r >= {1'b0, norm_ff}) begin
            r = r - {1'b0, norm_ff};
            q = {q[QUOT_W-2:0], 1'b1};
         end else begin
            q = {q[QUOT_W-2:0], 1'b0};
         end
      end
      div_rem_nx  = r;
      div_bits_nx = b;
      quot_nx     = q;
   end

   // quotient to signed result with saturation
   always_comb begin
      if (neg_ff) begin
         q_final = quot_ff[QUOT_W-1] ? SAT_NEG : VALUE_W'(~quot_ff + 1'b1);
      end else begin
         q_final = quot_ff[QUOT_W-1] ? SAT_POS : VALUE_W'(quot_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vln_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      count_in     = count_ff;
      pos_in       = pos_ff;
      ready_in     = ready_ff;
      overfill_in  = overfill_ff;
      sum_in       = sum_ff;
      norm_in      = norm_ff;
      sq_in        = sq_ff;
      close_in     = close_ff;
      root_src_in  = root_src_ff;
      root_rem_in  = root_rem_ff;
      root_in      = root_ff;
      step_in      = step_ff;
      skip_in      = skip_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      neg_in       = neg_ff;
      use_q_in     = use_q_ff;
      res_in       = res_ff;
      div_rem_in   = div_rem_ff;
      div_bits_in  = div_bits_ff;
      quot_in      = quot_ff;
      dcnt_in      = dcnt_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_err_in   = out_err_ff;

      case (state_ff)
         vln_pkg::ST_IDLE: begin
            if (!status.empty) begin
               pop = 1'b1;
               case (pop_cmd.op)
                  vln_pkg::OP_LOAD, vln_pkg::OP_LOAD_LAST: begin
                     // first load after a closed vector starts afresh
                     if (ready_ff) begin
                        ready_in    = 1'b0;
                        pos_in      = '0;
                        sum_in      = '0;
                        norm_in     = '0;
                        overfill_in = 1'b0;
                     end
                     if (count_eff < CNT_W'(VECTOR_LEN)) begin
                        mem_we   = 1'b1;
                        count_in = count_eff + 1'b1;
                        sq_in    = SQ_W'(sq_prod);
                     end else begin
                        overfill_in = 1'b1;
                        count_in    = count_eff;
                        sq_in       = '0;
                     end
                     close_in = (pop_cmd.op == vln_pkg::OP_LOAD_LAST);
                     state_in = vln_pkg::ST_ACCUM;
                  end
                  vln_pkg::OP_READ: begin
                     if (!ready_ff || pos_ff >= count_ff) begin
                        res_in   = '0;
                        use_q_in = 1'b0;
                        last_in  = 1'b0;
                        err_in   = 1'b1;
                        state_in = vln_pkg::ST_EMIT;
                     end else begin
                        mem_re   = 1'b1;
                        last_in  = ((pos_ff + 1'b1) == count_ff);
                        pos_in   = pos_ff + 1'b1;
                        err_in   = overfill_ff;
                        skip_in  = (sum_ff <= SUM_W'(tiny_sum_squares)) || (norm_ff == '0);
                        state_in = vln_pkg::ST_FETCH;
                     end
                  end
                  default: begin
                     state_in = vln_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         vln_pkg::ST_ACCUM: begin
            sum_in = accum_sat;
            if (close_ff) begin
               root_src_in = accum_sat;
               root_rem_in = '0;
               root_in     = '0;
               step_in     = '0;
               state_in    = vln_pkg::ST_ROOT;
            end else begin
               state_in = vln_pkg::ST_IDLE;
            end
         end

         vln_pkg::ST_ROOT: begin
            // one result bit per cycle
            root_src_in = root_src_ff << 2;
            root_rem_in = root_ge ? root_diff[ROOT_W+1:0] : root_wrk[ROOT_W+1:0];
            root_in     = {root_ff[ROOT_W-2:0], root_ge};
            step_in     = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               norm_in  = {root_ff[ROOT_W-2:0], root_ge};
               ready_in = 1'b1;
               pos_in   = '0;
               state_in = vln_pkg::ST_IDLE;
            end
         end

         vln_pkg::ST_FETCH: begin
            neg_in = rd_neg;
            if (skip_ff) begin
               res_in   = VALUE_W'(rd_ff);
               use_q_in = 1'b0;
               state_in = vln_pkg::ST_EMIT;
            end else if (div_sat) begin
               quot_in  = '1;
               use_q_in = 1'b1;
               state_in = vln_pkg::ST_EMIT;
            end else begin
               div_rem_in  = (ROOT_W + 1)'(mag16 >> SAT_SH);
               div_bits_in = QUOT_W'(mag16 << FRAC_BITS);
               quot_in     = '0;
               dcnt_in     = '0;
               use_q_in    = 1'b1;
               state_in    = vln_pkg::ST_DIVIDE;
            end
         end

         vln_pkg::ST_DIVIDE: begin
            div_rem_in  = div_rem_nx;
            div_bits_in = div_bits_nx;
            quot_in     = quot_nx;
            dcnt_in     = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(DIV_CYCLES - 1)) begin
               state_in = vln_pkg::ST_EMIT;
            end
         end

         vln_pkg::ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_value_in = use_q_ff ? q_final : res_ff;
               out_last_in  = last_ff;
               out_err_in   = err_ff;
               state_in     = vln_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = vln_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         ready_ff     <= 1'b0;
         overfill_ff  <= 1'b0;
         sum_ff       <= '0;
         norm_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         ready_ff     <= ready_in;
         overfill_ff  <= overfill_in;
         sum_ff       <= sum_in;
         norm_ff      <= norm_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff        <= sq_in;
      close_ff     <= close_in;
      root_src_ff  <= root_src_in;
      root_rem_ff  <= root_rem_in;
      root_ff      <= root_in;
      step_ff      <= step_in;
      skip_ff      <= skip_in;
      last_ff      <= last_in;
      err_ff       <= err_in;
      neg_ff       <= neg_in;
      use_q_ff     <= use_q_in;
      res_ff       <= res_in;
      div_rem_ff   <= div_rem_in;
      div_bits_ff  <= div_bits_in;
      quot_ff      <= quot_in;
      dcnt_ff      <= dcnt_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_err_ff   <= out_err_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= elem_v;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.normalized_value = out_value_ff;
   assign rsp.last_result      = out_last_ff;
   assign rsp.error_flag       = out_err_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(VECTOR_LEN))
      else $error("load count beyond store depth");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> pos_ff <= count_ff)
      else $error("read position beyond loaded length");

   a_root_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == vln_pkg::ST_ROOT |-> root_rem_ff <= {1'b0, root_ff, 1'b0})
      else $error("square root remainder out of range");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == vln_pkg::ST_DIVIDE |-> div_rem_ff < {1'b0, norm_ff})
      else $error("division remainder not below the norm");
`endif

endmodule

// File: design/vector_l2_normalizer.sv
// top level of the vector l2 normaliser
//
//  channel  direction  transfer carries
//  req_ch   in         kind, element_value, last_element
//  rsp_ch   out        normalized_value, last_result, error_flag
//  csr_ch   in         tiny_sum_squares (always ready)
//
// a load passes through ST_IDLE and ST_ACCUM in the back end, the closing load then
// also through the one-bit-per-cycle square root of the 40-bit sum of squares
// a normalised read runs store read, operand fetch, the 4-bit-per-cycle
// divider and the result; a pass-through or saturating read skips the divider,
// an error read goes from the decode straight to the result
// a 4-entry queue decouples the request side from the back end, and the
// result register lets the back end finish one more item while rsp_ch stalls
// synchronous active-high reset; the element store is not cleared
module vector_l2_normalizer #(
   parameter int VECTOR_LEN   = vln_pkg::VECTOR_LEN_DEF,
   parameter int ELEMENT_BITS = vln_pkg::ELEMENT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   vln_req_if.sink     req_ch,
   vln_rsp_if.source   rsp_ch,
   vln_csr_if.sink     csr_ch
);

   // threshold register
   logic [vln_pkg::TINY_W-1:0] tiny_ff, tiny_in;

   // front to queue
   logic                       push_valid;
   vln_pkg::cmd_type           push_cmd;

   // queue to back
   logic                       pop;
   vln_pkg::cmd_type           pop_cmd;
   vln_pkg::queue_status_type  status;

   // register writes need no wait
   assign csr_ch.ready = 1'b1;
   assign tiny_in      = csr_ch.valid ? csr_ch.tiny_sum_squares : tiny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tiny_ff <= '0;
      end else begin
         tiny_ff <= tiny_in;
      end
   end

   // decode and clamp
   vln_front #(
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_front (
      .req        (req_ch),
      .status     (status),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // command queue
   vln_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .pop_cmd    (pop_cmd),
      .status     (status)
   );

   // store, accumulate, root, divide
   vln_back #(
      .VECTOR_LEN   (VECTOR_LEN),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .tiny_sum_squares (tiny_ff),
      .status           (status),
      .pop_cmd          (pop_cmd),
      .pop              (pop),
      .rsp              (rsp_ch)
   );

endmodule
